FILE: rtl/rmq_pkg.sv
// Shared types and constants of the rotation-matrix-to-quaternion block.
// Depends on nothing; used by rmq_front, rmq_back and the top level.
package rmq_pkg;

  localparam int FracBits = 14;
  localparam int DataW    = 16;
  localparam int ThrW     = 8;
  localparam int TrW      = DataW + 2;
  localparam int RadW     = DataW + 1;
  localparam int MagW     = DataW + 1;
  localparam int SqInW    = RadW + FracBits - 2;
  localparam int SqSteps  = (SqInW + 1) / 2;
  localparam int SqW      = 2 * SqSteps;
  localparam int ResW     = SqSteps;
  localparam int RemW     = ResW + 3;
  localparam int RootW    = ResW + 1;
  localparam int DenW     = RootW + 1;
  localparam int DivNW    = MagW + FracBits;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    CaseTrace = 2'd0,
    CaseX     = 2'd1,
    CaseY     = 2'd2,
    CaseZ     = 2'd3
  } case_e;

  // classified item: radicand and the three non-large numerators
  typedef struct packed {
    case_e                      sel;
    logic [RadW-1:0]            rad;
    logic [2:0]                 neg;
    logic [2:0][MagW-1:0]       mag;
  } item_t;

  typedef struct packed {
    case_e                      sel;
    logic [2:0]                 neg;
    logic [2:0][MagW-1:0]       mag;
    logic [SqW-1:0]             rad_sh;
    logic [ResW-1:0]            res;
    logic [RemW-1:0]            rem;
  } sq_t;

  typedef struct packed {
    case_e                      sel;
    logic [2:0]                 neg;
    logic [RootW-1:0]           root;
    logic [2:0][DivNW-1:0]      num;
    logic [2:0][DenW-1:0]       drem;
  } dv_t;

endpackage

FILE: rtl/rmq_front.sv
// Front end: trace threshold register, branch selection and a short queue.
// Depends on rmq_pkg.
module rmq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rmq_pkg::ThrW-1:0]    cfg_wdata_i,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [9*rmq_pkg::DataW-1:0] s_data_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output rmq_pkg::item_t              q_item_o
);

  localparam int W = rmq_pkg::DataW;

  logic [rmq_pkg::ThrW-1:0] thr_q;
  logic signed [W-1:0] d0, d1, d2, m01, m10, m02, m20, m12, m21;
  logic signed [rmq_pkg::TrW-1:0] tr;
  logic signed [rmq_pkg::TrW:0] rad_s;
  logic signed [rmq_pkg::MagW-1:0] n [3];
  rmq_pkg::item_t item;
  rmq_pkg::item_t q_mem [rmq_pkg::QDepth];
  logic [rmq_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [rmq_pkg::QCntW-1:0] cnt_q;
  logic push, pop;
  logic [1:0] big;

  assign d0  = s_data_i[0*W +: W];
  assign m10 = s_data_i[1*W +: W];
  assign m20 = s_data_i[2*W +: W];
  assign m01 = s_data_i[3*W +: W];
  assign d1  = s_data_i[4*W +: W];
  assign m21 = s_data_i[5*W +: W];
  assign m02 = s_data_i[6*W +: W];
  assign m12 = s_data_i[7*W +: W];
  assign d2  = s_data_i[8*W +: W];

  always_comb begin
    tr  = rmq_pkg::TrW'(d0) + rmq_pkg::TrW'(d1) + rmq_pkg::TrW'(d2);
    big = 2'd0;
    if (d1 > d0) big = 2'd1;
    if (d2 > ((big == 2'd0) ? d0 : d1)) big = 2'd2;
    if (tr >= $signed({{(rmq_pkg::TrW-rmq_pkg::ThrW){1'b0}}, thr_q})) begin
      item.sel = rmq_pkg::CaseTrace;
      rad_s = (rmq_pkg::TrW+1)'(tr) + (rmq_pkg::TrW+1)'(1 << rmq_pkg::FracBits);
      n[0] = rmq_pkg::MagW'(m21) - rmq_pkg::MagW'(m12);
      n[1] = rmq_pkg::MagW'(m02) - rmq_pkg::MagW'(m20);
      n[2] = rmq_pkg::MagW'(m10) - rmq_pkg::MagW'(m01);
    end else begin
      case (big)
        2'd0: begin
          item.sel = rmq_pkg::CaseX;
          rad_s = (rmq_pkg::TrW+1)'(d0) - ((rmq_pkg::TrW+1)'(d1) + (rmq_pkg::TrW+1)'(d2))
                  + (rmq_pkg::TrW+1)'(1 << rmq_pkg::FracBits);
          n[0] = rmq_pkg::MagW'(m01) + rmq_pkg::MagW'(m10);
          n[1] = rmq_pkg::MagW'(m20) + rmq_pkg::MagW'(m02);
          n[2] = rmq_pkg::MagW'(m21) - rmq_pkg::MagW'(m12);
        end
        2'd1: begin
          item.sel = rmq_pkg::CaseY;
          rad_s = (rmq_pkg::TrW+1)'(d1) - ((rmq_pkg::TrW+1)'(d2) + (rmq_pkg::TrW+1)'(d0))
                  + (rmq_pkg::TrW+1)'(1 << rmq_pkg::FracBits);
          n[0] = rmq_pkg::MagW'(m01) + rmq_pkg::MagW'(m10);
          n[1] = rmq_pkg::MagW'(m12) + rmq_pkg::MagW'(m21);
          n[2] = rmq_pkg::MagW'(m02) - rmq_pkg::MagW'(m20);
        end
        default: begin
          item.sel = rmq_pkg::CaseZ;
          rad_s = (rmq_pkg::TrW+1)'(d2) - ((rmq_pkg::TrW+1)'(d0) + (rmq_pkg::TrW+1)'(d1))
                  + (rmq_pkg::TrW+1)'(1 << rmq_pkg::FracBits);
          n[0] = rmq_pkg::MagW'(m02) + rmq_pkg::MagW'(m20);
          n[1] = rmq_pkg::MagW'(m12) + rmq_pkg::MagW'(m21);
          n[2] = rmq_pkg::MagW'(m10) - rmq_pkg::MagW'(m01);
        end
      endcase
    end
    // radicand clamped to one LSB
    if (rad_s < 1) item.rad = rmq_pkg::RadW'(1);
    else item.rad = rad_s[rmq_pkg::RadW-1:0];
    for (int k = 0; k < 3; k++) begin
      item.neg[k] = n[k][rmq_pkg::MagW-1];
      item.mag[k] = n[k][rmq_pkg::MagW-1] ? rmq_pkg::MagW'(-n[k]) : rmq_pkg::MagW'(n[k]);
    end
  end

  assign s_ready_o = (cnt_q != rmq_pkg::QCntW'(rmq_pkg::QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = q_mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= item;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rmq_pkg::QCntW'(rmq_pkg::QDepth)) else $error("queue overfilled");
  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_o && !q_ready_i |=> q_valid_o) else $error("queue head lost");

endmodule

FILE: rtl/rmq_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation.
// Depends on rmq_pkg.
module rmq_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  rmq_pkg::item_t                q_item_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [4*rmq_pkg::DataW-1:0]   m_data_o,
  output logic [1:0]                    m_user_o
);

  localparam int W      = rmq_pkg::DataW;
  localparam int RootWL = rmq_pkg::RootW;

  logic en;
  logic [rmq_pkg::SqSteps:0] sv_q;
  logic [rmq_pkg::DivNW:0]   dvv_q;
  logic                      ov_q;
  rmq_pkg::sq_t sq_q [rmq_pkg::SqSteps+1];
  rmq_pkg::dv_t dv_q [rmq_pkg::DivNW+1];
  rmq_pkg::dv_t dv_init;
  logic [4*W-1:0] od_q;
  logic [1:0]     ou_q;
  logic [W-1:0]   qs [3];
  logic [W-1:0]   rs;
  logic [RootWL-1:0] root_r;

  assign en        = !ov_q || m_ready_i;
  assign q_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q  <= '0;
      dvv_q <= '0;
      ov_q  <= 1'b0;
    end else if (en) begin
      sv_q  <= {sv_q[rmq_pkg::SqSteps-1:0], q_valid_i};
      dvv_q <= {dvv_q[rmq_pkg::DivNW-1:0], sv_q[rmq_pkg::SqSteps]};
      ov_q  <= dvv_q[rmq_pkg::DivNW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].sel    <= q_item_i.sel;
      sq_q[0].neg    <= q_item_i.neg;
      sq_q[0].mag    <= q_item_i.mag;
      sq_q[0].rad_sh <= rmq_pkg::SqW'({q_item_i.rad, {(rmq_pkg::FracBits-2){1'b0}}});
      sq_q[0].res    <= '0;
      sq_q[0].rem    <= '0;
    end
  end

  for (genvar g = 0; g < rmq_pkg::SqSteps; g++) begin : g_sq
    logic [rmq_pkg::RemW-1:0] rem2, trial;
    rmq_pkg::sq_t nx;
    always_comb begin
      nx     = sq_q[g];
      rem2   = {sq_q[g].rem[rmq_pkg::RemW-3:0], sq_q[g].rad_sh[rmq_pkg::SqW-1 -: 2]};
      trial  = rmq_pkg::RemW'({sq_q[g].res, 2'b01});
      nx.rad_sh = {sq_q[g].rad_sh[rmq_pkg::SqW-3:0], 2'b00};
      if (rem2 >= trial) begin
        nx.rem = rem2 - trial;
        nx.res = {sq_q[g].res[rmq_pkg::ResW-2:0], 1'b1};
      end else begin
        nx.rem = rem2;
        nx.res = {sq_q[g].res[rmq_pkg::ResW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[g+1] <= nx;
    end
  end

  always_comb begin
    root_r = RootWL'(sq_q[rmq_pkg::SqSteps].res)
           + ((RootWL'(sq_q[rmq_pkg::SqSteps].rem) > RootWL'(sq_q[rmq_pkg::SqSteps].res))
              ? RootWL'(1) : RootWL'(0));
    if (root_r == '0) root_r = RootWL'(1);
    dv_init.sel  = sq_q[rmq_pkg::SqSteps].sel;
    dv_init.neg  = sq_q[rmq_pkg::SqSteps].neg;
    dv_init.root = root_r;
    for (int k = 0; k < 3; k++) begin
      dv_init.num[k]  = rmq_pkg::DivNW'({sq_q[rmq_pkg::SqSteps].mag[k],
                                         {(rmq_pkg::FracBits-1){1'b0}}})
                      + rmq_pkg::DivNW'(root_r);
      dv_init.drem[k] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= dv_init;
  end

  // restoring division of (2|n| + q) by 2q, one quotient bit per stage
  for (genvar g = 0; g < rmq_pkg::DivNW; g++) begin : g_dv
    rmq_pkg::dv_t nx;
    logic [rmq_pkg::DenW:0] r [3];
    logic [rmq_pkg::DenW:0] den;
    always_comb begin
      nx  = dv_q[g];
      den = (rmq_pkg::DenW+1)'({dv_q[g].root, 1'b0});
      for (int k = 0; k < 3; k++) begin
        r[k] = {dv_q[g].drem[k], dv_q[g].num[k][rmq_pkg::DivNW-1]};
        if (r[k] >= den) begin
          nx.drem[k] = rmq_pkg::DenW'(r[k] - den);
          nx.num[k]  = {dv_q[g].num[k][rmq_pkg::DivNW-2:0], 1'b1};
        end else begin
          nx.drem[k] = rmq_pkg::DenW'(r[k]);
          nx.num[k]  = {dv_q[g].num[k][rmq_pkg::DivNW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[g+1] <= nx;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!dv_q[rmq_pkg::DivNW].neg[k]) begin
        if (dv_q[rmq_pkg::DivNW].num[k] > rmq_pkg::DivNW'(32767)) qs[k] = 16'h7fff;
        else qs[k] = dv_q[rmq_pkg::DivNW].num[k][W-1:0];
      end else begin
        if (dv_q[rmq_pkg::DivNW].num[k] > rmq_pkg::DivNW'(32768)) qs[k] = 16'h8000;
        else qs[k] = W'(-dv_q[rmq_pkg::DivNW].num[k][W-1:0]);
      end
    end
    if (dv_q[rmq_pkg::DivNW].root > RootWL'(32767)) rs = 16'h7fff;
    else rs = W'(dv_q[rmq_pkg::DivNW].root);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ou_q <= dv_q[rmq_pkg::DivNW].sel;
      case (dv_q[rmq_pkg::DivNW].sel)
        rmq_pkg::CaseTrace: od_q <= {rs, qs[2], qs[1], qs[0]};
        rmq_pkg::CaseX:     od_q <= {qs[2], qs[1], qs[0], rs};
        rmq_pkg::CaseY:     od_q <= {qs[2], qs[1], rs, qs[0]};
        default:            od_q <= {qs[2], rs, qs[1], qs[0]};
      endcase
    end
  end

  assign m_valid_o = ov_q;
  assign m_data_o  = od_q;
  assign m_user_o  = ou_q;

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvv_q[0] |-> dv_q[0].root != '0) else $error("zero divisor");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !m_ready_i |=> $stable(sv_q) && $stable(dvv_q)) else $error("pipe moved in stall");

endmodule

FILE: rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter, top level.
// Depends on rmq_pkg, rmq_front and rmq_back.
//
// Takes one 3x3 rotation matrix per cycle while s_axis_tready is high (Q1.14,
// column by column in s_axis_tdata) and returns (x, y, z, w) in Q1.14 plus the
// branch taken in m_axis_tuser. The pipeline holds the 15-stage square root and
// the 31-stage dividers. A four-word queue after the classifier keeps input
// flowing while the output is stalled, until the queue is full.
module rotation_matrix_to_quaternion (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rmq_pkg::ThrW-1:0]    cfg_wdata_i,   // trace_threshold
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
  // col2_row0, col2_row1, col2_row2
  input  logic [9*rmq_pkg::DataW-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [4*rmq_pkg::DataW-1:0] m_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
  output logic [1:0]                  m_axis_tuser   // case_taken
);

  logic           q_valid, q_ready;
  rmq_pkg::item_t q_item;

  rmq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  rmq_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

endmodule
